### rtl/matrix4x4_row_transform_core_macros.svh
// assertion macros shared by the checker
`ifndef MATRIX4X4_ROW_TRANSFORM_CORE_MACROS_SVH
`define MATRIX4X4_ROW_TRANSFORM_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define MRT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define MRT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define MRT_ASSERT_NXT_ALL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mrt_pkg.sv
package mrt_pkg;

   localparam int WORD_W     = 32;
   localparam int PROD_W     = 64;
   localparam int SUM_W      = 66;  // four full products plus growth
   localparam int INDEX_W    = 4;
   localparam int ROW_FIELDS = 4;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_ROW  = 1'b1;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   localparam sum_type SAT_MAX = {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
   localparam sum_type SAT_MIN = {{(SUM_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // capture enables for the column pipeline stages
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

endpackage

### rtl/mrt_bstore.sv
module mrt_bstore #(
   parameter int DIM       = 4,
   parameter int NK        = 4,
   parameter int NC        = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_en,
   input  logic [mrt_pkg::INDEX_W-1:0]   load_index,
   input  mrt_pkg::word_type             load_value,
   output mrt_pkg::word_type             b_o [NK][NC]
);
   import mrt_pkg::*;

   localparam word_type UNIT = word_type'(1) <<< FRAC_BITS;

   word_type b_ff [NK][NC];

   for (genvar k = 0; k < NK; k++) begin : g_row
      for (genvar c = 0; c < NC; c++) begin : g_col
         localparam int FLAT = k * DIM + c;
         localparam word_type INIT = (k == c) ? UNIT : '0;
         logic hit;

         // entries past the index range never match
         if (FLAT < (1 << INDEX_W)) begin : g_addr
            assign hit = load_en && (load_index == INDEX_W'(FLAT));
         end else begin : g_noaddr
            assign hit = 1'b0;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               b_ff[k][c] <= INIT;
            end else if (hit) begin
               b_ff[k][c] <= load_value;
            end
         end

         assign b_o[k][c] = b_ff[k][c];
      end
   end

endmodule

### rtl/mrt_col.sv
module mrt_col #(
   parameter int NK        = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  mrt_pkg::stage_en_type en,
   input  mrt_pkg::word_type     row_elem [NK],
   input  mrt_pkg::word_type     b_col    [NK],
   output mrt_pkg::word_type     prod_elem,
   output logic                  saturated
);
   import mrt_pkg::*;

   localparam int HALF = (NK + 1) / 2;

   prod_type prod_ff [NK];
   sum_type  half_a_in, half_b_in, half_a_ff, half_b_ff;
   sum_type  shift_in, shift_ff;
   word_type out_in, out_ff;
   logic     sat_in, sat_ff;

   // stage 2: one product per term
   always_ff @(posedge clock) begin
      if (en.s2) begin
         for (int k = 0; k < NK; k++) begin
            prod_ff[k] <= prod_type'(row_elem[k]) * prod_type'(b_col[k]);
         end
      end
   end

   // stage 3: two partial sums
   always_comb begin
      half_a_in = '0;
      half_b_in = '0;
      for (int k = 0; k < HALF; k++) begin
         half_a_in = half_a_in + sum_type'(prod_ff[k]);
      end
      for (int k = HALF; k < NK; k++) begin
         half_b_in = half_b_in + sum_type'(prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         half_a_ff <= half_a_in;
         half_b_ff <= half_b_in;
      end
   end

   // stage 4: final add, drop fraction bits toward minus infinity
   assign shift_in = (half_a_ff + half_b_ff) >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (en.s4) begin
         shift_ff <= shift_in;
      end
   end

   // stage 5: clip to one word
   always_comb begin
      priority if (shift_ff > SAT_MAX) begin
         out_in = WORD_MAX;
         sat_in = 1'b1;
      end else if (shift_ff < SAT_MIN) begin
         out_in = WORD_MIN;
         sat_in = 1'b1;
      end else begin
         out_in = shift_ff[WORD_W-1:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         out_ff <= out_in;
         sat_ff <= sat_in;
      end
   end

   assign prod_elem = out_ff;
   assign saturated = sat_ff;

endmodule

### rtl/matrix4x4_row_transform_core.sv
// a row word accepted on the request side passes the input register, multiply, half sums,
// final add and clip registers in that order, shows on rsp_valid and is taken while rsp_stall is low
// throughput: one word per cycle, loads and rows alike, while the receiver does not stall
// a load word writes B at its accept edge and makes no response word
// reset (synchronous, active high) empties the pipeline and sets B to identity
// the five stages are input register, multiply, half sums, final add, clip
module matrix4x4_row_transform_core #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cmd,
   input  logic [mrt_pkg::INDEX_W-1:0] req_load_index,
   input  mrt_pkg::word_type           req_load_value,
   input  mrt_pkg::word_type           req_row_elem0,
   input  mrt_pkg::word_type           req_row_elem1,
   input  mrt_pkg::word_type           req_row_elem2,
   input  mrt_pkg::word_type           req_row_elem3,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output mrt_pkg::word_type           rsp_prod_elem0,
   output mrt_pkg::word_type           rsp_prod_elem1,
   output mrt_pkg::word_type           rsp_prod_elem2,
   output mrt_pkg::word_type           rsp_prod_elem3,
   output logic                        rsp_saturated
);
   import mrt_pkg::*;

   // only the terms and columns that reach the four row fields matter
   localparam int NK = (DIM < ROW_FIELDS) ? DIM : ROW_FIELDS;
   localparam int NC = NK;

   // stage valids, travel with the data
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   logic acc_row, acc_load;
   stage_en_type en;

   word_type row_in  [ROW_FIELDS];
   word_type row_ff  [NK];
   word_type b_w     [NK][NC];
   word_type prod_w  [ROW_FIELDS];
   logic     sat_w   [ROW_FIELDS];

   // each stage may take new data when it is empty or its content moves on,
   // so bubbles collapse and a waiting response blocks upstream only once the stages behind it are full
   assign rdy5 = !v5_ff || !rsp_stall;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_stall = !rdy1;
   assign acc_row   = req_valid && rdy1 && (req_cmd == CMD_ROW);
   assign acc_load  = req_valid && rdy1 && (req_cmd == CMD_LOAD);

   assign v1_in = rdy1 ? acc_row : v1_ff;
   assign v2_in = rdy2 ? v1_ff   : v2_ff;
   assign v3_in = rdy3 ? v2_ff   : v3_ff;
   assign v4_in = rdy4 ? v3_ff   : v4_ff;
   assign v5_in = rdy5 ? v4_ff   : v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // data moves only when a valid word enters the stage
   assign en.s2 = rdy2 && v1_ff;
   assign en.s3 = rdy3 && v2_ff;
   assign en.s4 = rdy4 && v3_ff;
   assign en.s5 = rdy5 && v4_ff;

   // stage 1: input row register
   assign row_in[0] = req_row_elem0;
   assign row_in[1] = req_row_elem1;
   assign row_in[2] = req_row_elem2;
   assign row_in[3] = req_row_elem3;

   always_ff @(posedge clock) begin
      if (acc_row) begin
         for (int k = 0; k < NK; k++) begin
            row_ff[k] <= row_in[k];
         end
      end
   end

   // B is read by the multiply stage; a load is only taken when stage 1 is
   // empty or moving on, so a row ahead of the load always sees the old B
   mrt_bstore #(
      .DIM       (DIM),
      .NK        (NK),
      .NC        (NC),
      .FRAC_BITS (FRAC_BITS)
   ) u_bstore (
      .clock      (clock),
      .reset      (reset),
      .load_en    (acc_load),
      .load_index (req_load_index),
      .load_value (req_load_value),
      .b_o        (b_w)
   );

   // one column pipeline per result field that the dimension reaches
   for (genvar c = 0; c < ROW_FIELDS; c++) begin : g_col
      if (c < NC) begin : g_live
         word_type b_col [NK];

         for (genvar k = 0; k < NK; k++) begin : g_tap
            assign b_col[k] = b_w[k][c];
         end

         mrt_col #(
            .NK        (NK),
            .FRAC_BITS (FRAC_BITS)
         ) u_col (
            .clock     (clock),
            .en        (en),
            .row_elem  (row_ff),
            .b_col     (b_col),
            .prod_elem (prod_w[c]),
            .saturated (sat_w[c])
         );
      end else begin : g_dead
         // columns beyond the dimension read as zero
         assign prod_w[c] = '0;
         assign sat_w[c]  = 1'b0;
      end
   end

   // response word straight from the stage 5 registers
   assign rsp_valid      = v5_ff;
   assign rsp_prod_elem0 = prod_w[0];
   assign rsp_prod_elem1 = prod_w[1];
   assign rsp_prod_elem2 = prod_w[2];
   assign rsp_prod_elem3 = prod_w[3];
   assign rsp_saturated  = sat_w[0] || sat_w[1] || sat_w[2] || sat_w[3];

endmodule

### rtl/mrt_checker.sv
module mrt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_cmd,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input mrt_pkg::word_type           rsp_prod_elem0,
   input mrt_pkg::word_type           rsp_prod_elem1,
   input mrt_pkg::word_type           rsp_prod_elem2,
   input mrt_pkg::word_type           rsp_prod_elem3,
   input logic                        rsp_saturated
);
   import mrt_pkg::*;

`include "matrix4x4_row_transform_core_macros.svh"

   logic                    row_acc, any_clip;
   logic [4*WORD_W:0]       rsp_word;

   assign row_acc  = req_valid && !req_stall && (req_cmd == CMD_ROW);
   assign rsp_word = {rsp_prod_elem0, rsp_prod_elem1, rsp_prod_elem2,
                      rsp_prod_elem3, rsp_saturated};
   assign any_clip = (rsp_prod_elem0 == WORD_MAX) || (rsp_prod_elem0 == WORD_MIN) ||
                     (rsp_prod_elem1 == WORD_MAX) || (rsp_prod_elem1 == WORD_MIN) ||
                     (rsp_prod_elem2 == WORD_MAX) || (rsp_prod_elem2 == WORD_MIN) ||
                     (rsp_prod_elem3 == WORD_MAX) || (rsp_prod_elem3 == WORD_MIN);

   `MRT_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "response word changed while stalled")
   `MRT_ASSERT_IMP(a_sat_clip, rsp_valid && rsp_saturated, any_clip, "saturated flag without a clipped column")
   `MRT_ASSERT_NXT_ALL(a_reset_empty, reset, !rsp_valid, "response valid right after reset")
   `MRT_ASSERT_NXT(a_row_latency, (row_acc && !rsp_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall, rsp_valid, "row word missing after pipeline latency")

endmodule

bind matrix4x4_row_transform_core mrt_checker u_mrt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_cmd        (req_cmd),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_prod_elem0 (rsp_prod_elem0),
   .rsp_prod_elem1 (rsp_prod_elem1),
   .rsp_prod_elem2 (rsp_prod_elem2),
   .rsp_prod_elem3 (rsp_prod_elem3),
   .rsp_saturated  (rsp_saturated)
);

### bench/mrt_row_checker.sv
`timescale 1ns / 100ps

module mrt_row_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_cmd,
   input  logic [mrt_pkg::INDEX_W-1:0] req_load_index,
   input  mrt_pkg::word_type           req_load_value,
   input  mrt_pkg::word_type           req_row_elem0,
   input  mrt_pkg::word_type           req_row_elem1,
   input  mrt_pkg::word_type           req_row_elem2,
   input  mrt_pkg::word_type           req_row_elem3,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  mrt_pkg::word_type           rsp_prod_elem0,
   input  mrt_pkg::word_type           rsp_prod_elem1,
   input  mrt_pkg::word_type           rsp_prod_elem2,
   input  mrt_pkg::word_type           rsp_prod_elem3,
   input  logic                        rsp_saturated,
   output int                          error_count,
   output int                          rows_in_flight
);
   import mrt_pkg::*;

   localparam int      DIM     = 4;
   localparam int      FRAC    = 16;
   localparam sum_type CLIP_HI = sum_type'(WORD_MAX);
   localparam sum_type CLIP_LO = sum_type'(WORD_MIN);

   typedef struct packed {
      logic [ROW_FIELDS-1:0][WORD_W-1:0] elem;
      logic                              sat;
   } out_row_type;

   word_type    b_matrix [DIM*DIM];
   out_row_type expected_rows [$];

   // one row times the held B: full-width sum, floor shift, clip to 32 bits
   function automatic out_row_type multiply_row(input word_type a0, a1, a2, a3);
      word_type    a [DIM];
      sum_type     acc;
      sum_type     scaled;
      out_row_type res;
      int          c;
      int          k;
      a[0] = a0;
      a[1] = a1;
      a[2] = a2;
      a[3] = a3;
      res.sat = 1'b0;
      for (c = 0; c < DIM; c++) begin
         acc = '0;
         for (k = 0; k < DIM; k++)
            acc = acc + a[k] * b_matrix[k*DIM + c];
         scaled = acc >>> FRAC;
         if (scaled > CLIP_HI) begin
            res.elem[c] = WORD_MAX;
            res.sat     = 1'b1;
         end else if (scaled < CLIP_LO) begin
            res.elem[c] = WORD_MIN;
            res.sat     = 1'b1;
         end else begin
            res.elem[c] = scaled[WORD_W-1:0];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      out_row_type got;
      out_row_type want;
      int          i;
      if (reset) begin
         for (i = 0; i < DIM*DIM; i++)
            b_matrix[i] = (i % (DIM + 1) == 0) ? word_type'(1 << FRAC) : word_type'(0);
         expected_rows.delete();
         error_count = 0;
      end else begin
         // results first: a result leaving now belongs to an older row
         if (rsp_valid && !rsp_stall) begin
            got.elem = {rsp_prod_elem3, rsp_prod_elem2, rsp_prod_elem1, rsp_prod_elem0};
            got.sat  = rsp_saturated;
            if (expected_rows.size() == 0) begin
               error_count++;
               $display("%0t: result word with no row pending, expected none actual %h sat %b",
                        $time, got.elem, got.sat);
            end else begin
               want = expected_rows.pop_front();
               for (i = 0; i < ROW_FIELDS; i++)
                  if (got.elem[i] !== want.elem[i]) begin
                     error_count++;
                     $display("%0t: prod_elem%0d expected %h actual %h",
                              $time, i, want.elem[i], got.elem[i]);
                  end
               if (got.sat !== want.sat) begin
                  error_count++;
                  $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_cmd == CMD_ROW)
               expected_rows.push_back(multiply_row(req_row_elem0, req_row_elem1,
                                                    req_row_elem2, req_row_elem3));
            else
               b_matrix[req_load_index] = req_load_value;
         end
      end
      rows_in_flight = expected_rows.size();
   end

endmodule

### bench/tb_matrix4x4_row_transform_core.sv
`timescale 1ns / 100ps

module tb_matrix4x4_row_transform_core;
   import mrt_pkg::*;

   localparam int       WATCHDOG_LIMIT = 3000;  // cycles with no word moving
   localparam int       HOLD_CYCLES    = 80;    // long receiver hold-off
   localparam int       DRAIN_CYCLES   = 12;    // pipeline is five deep
   localparam word_type Q_ONE          = 32'sh0001_0000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_cmd;
   logic [INDEX_W-1:0] req_load_index;
   word_type           req_load_value;
   word_type           req_row_elem0;
   word_type           req_row_elem1;
   word_type           req_row_elem2;
   word_type           req_row_elem3;
   logic               rsp_valid;
   logic               rsp_stall;
   word_type           rsp_prod_elem0;
   word_type           rsp_prod_elem1;
   word_type           rsp_prod_elem2;
   word_type           rsp_prod_elem3;
   logic               rsp_saturated;

   int   error_count;
   int   rows_in_flight;
   int   gap_pct;       // chance per word that the sender idles first
   int   stall_pct;     // chance per cycle that the receiver starts a stall burst
   logic hold_request;  // asks the receiver for one long hold-off

   matrix4x4_row_transform_core dut (.*);

   mrt_row_checker row_check (.*);

   // 100 MHz
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin : receiver
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(1, 100) <= stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // put one word on the request side and hold it until taken
   task automatic offer_word(input logic cmd, input logic [INDEX_W-1:0] idx,
                             input word_type value, r0, r1, r2, r3);
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_load_index <= idx;
      req_load_value <= value;
      req_row_elem0  <= r0;
      req_row_elem1  <= r1;
      req_row_elem2  <= r2;
      req_row_elem3  <= r3;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // load word: row fields carry junk that must be ignored
   task automatic load_elem(input logic [INDEX_W-1:0] idx, input word_type value);
      offer_word(CMD_LOAD, idx, value, $urandom, $urandom, $urandom, $urandom);
   endtask

   // row word: load fields carry junk that must be ignored
   task automatic send_row(input word_type r0, r1, r2, r3);
      offer_word(CMD_ROW, INDEX_W'($urandom_range(0, 15)), $urandom, r0, r1, r2, r3);
   endtask

   // sender goes quiet until every expected result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (rows_in_flight != 0);
      @(posedge clock);
   endtask

   // value mix: extremes, full random, small reals, tiny raw values, plus or minus one
   function automatic word_type pick_value();
      case ($urandom_range(0, 7))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2, 3:    return word_type'($urandom);
         4, 5:    return word_type'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         6:       return word_type'($urandom_range(0, 255)) - 32'sd128;
         default: return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
      endcase
   endfunction

   // random mix of loads and rows with sender idling per gap_pct
   task automatic random_words(input int count, input int row_pct);
      repeat (count) begin
         if ($urandom_range(1, 100) <= gap_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         if ($urandom_range(1, 100) <= row_pct)
            send_row(pick_value(), pick_value(), pick_value(), pick_value());
         else
            load_elem(INDEX_W'($urandom_range(0, 15)), pick_value());
      end
   endtask

   // watchdog: ends the run if nothing moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_matrix4x4_row_transform_core failed");
      $finish;
   end

   initial begin : stimulus
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_LOAD;
      req_load_index = '0;
      req_load_value = '0;
      req_row_elem0  = '0;
      req_row_elem1  = '0;
      req_row_elem2  = '0;
      req_row_elem3  = '0;
      hold_request   = 1'b0;
      gap_pct        = 0;
      stall_pct      = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // B is the identity after reset: rows come back unchanged
      send_row(Q_ONE, 0, 0, 0);
      send_row(WORD_MAX, WORD_MIN, -1, 0);
      send_row(0, 0, 0, 0);
      send_row(-Q_ONE, Q_ONE / 2, 32'sh7FFF_0000, -32'sh0000_8000);

      // a load word alone makes no result; bottom-right index, the last one
      load_elem(4'd15, 32'sh0002_0000);
      send_row(0, 0, 0, 32'sh0003_0000);

      // positive overflow: two huge products summed into column 0
      load_elem(4'd0, WORD_MAX);
      load_elem(4'd4, WORD_MAX);
      send_row(WORD_MAX, WORD_MAX, 0, 0);
      // negative overflow
      send_row(WORD_MIN, WORD_MIN, 0, 0);
      // most negative times most negative
      load_elem(4'd5, WORD_MIN);
      send_row(0, WORD_MIN, 0, 0);

      // negative sums round toward minus infinity, positive ones toward zero
      load_elem(4'd0, 32'sd1);
      send_row(-1, 0, 0, 0);
      send_row(1, 0, 0, 0);

      // clip boundaries: exact fit in column 0, one past it in column 1
      load_elem(4'd0, Q_ONE);
      load_elem(4'd4, 0);
      load_elem(4'd5, Q_ONE);
      load_elem(4'd1, Q_ONE);
      send_row(WORD_MAX, 1, 0, 0);
      send_row(WORD_MIN, -1, 0, 0);
      wait_drained();

      // random traffic with both sides idling
      gap_pct   = 30;
      stall_pct <= 30;
      random_words(150, 75);

      // stretch with no idling at all
      gap_pct   = 0;
      stall_pct <= 0;
      random_words(80, 75);

      gap_pct   = 50;
      stall_pct <= 10;
      random_words(100, 75);

      // receiver holds off while rows keep coming, so the pipe fills up
      // and pushes back on the request side
      gap_pct   = 0;
      stall_pct <= 0;
      hold_request <= 1'b1;
      random_words(40, 100);
      wait_drained();

      // heavy receiver stalls, more loads in the mix
      gap_pct   = 20;
      stall_pct <= 50;
      random_words(150, 60);
      wait_drained();

      gap_pct   = 10;
      stall_pct <= 10;
      random_words(60, 75);

      // closing part runs at full rate
      gap_pct   = 0;
      stall_pct <= 0;
      random_words(80, 80);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_matrix4x4_row_transform_core passed");
      else
         $display("tb_matrix4x4_row_transform_core failed");
      $finish;
   end

endmodule
